### sv/delimiter_word_tokenizer_core_defines.svh
// Assertion macros for the delimiter word tokenizer.
// Included by the modules that carry concurrent assertions; needs no other file.
`ifndef DELIMITER_WORD_TOKENIZER_CORE_DEFINES_SVH
`define DELIMITER_WORD_TOKENIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge out of reset.
`define DWT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define DWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DWT_ASSERT(label, clk, rst_n, prop, msg)
`define DWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/dwt_pkg.sv
// Shared types, constants and character classes of the delimiter word tokenizer.
// Used by the core and the testbench; depends on nothing.
package dwt_pkg;

    localparam int DWT_MAX_TEXT_LEN = 65536;
    localparam int Q_DEPTH          = 4;

    localparam logic [7:0] MIN_WORD_LEN_RESET = 8'd1;

    localparam logic [7:0] CHAR_AMP    = 8'h26; // '&'
    localparam logic [7:0] CHAR_N      = 8'h6E; // 'n'
    localparam logic [7:0] CHAR_B      = 8'h62; // 'b'
    localparam logic [7:0] CHAR_S      = 8'h73; // 's'
    localparam logic [7:0] CHAR_P      = 8'h70; // 'p'
    localparam logic [7:0] CHAR_SEMI   = 8'h3B; // ';'
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_TAB    = 8'h09;

    // Number of entity bytes matched once only the final ';' is missing.
    localparam logic [2:0] ENT_LAST_IDX = 3'd5;

    typedef struct packed {
        logic        word_valid;
        logic [15:0] word_start;
        logic [15:0] word_length;
        logic        last_result;
    } result_t;

    function automatic logic is_delim(input logic [7:0] b);
        is_delim = (b == CHAR_COMMA)  || (b == CHAR_SPACE)  || (b == CHAR_QUOTE) ||
                   (b == CHAR_LPAREN) || (b == CHAR_RPAREN) || (b == CHAR_STAR)  ||
                   (b == CHAR_SLASH)  || (b == CHAR_COLON)  || (b == CHAR_DOT)   ||
                   (b == CHAR_NL)     || (b == CHAR_TAB);
    endfunction

    // Byte expected next, given how many bytes of "&nbsp;" are matched.
    function automatic logic [7:0] entity_char(input logic [2:0] idx);
        unique case (idx)
            3'd1:    entity_char = CHAR_N;
            3'd2:    entity_char = CHAR_B;
            3'd3:    entity_char = CHAR_S;
            3'd4:    entity_char = CHAR_P;
            3'd5:    entity_char = CHAR_SEMI;
            default: entity_char = CHAR_AMP;
        endcase
    endfunction

endpackage

### sv/dwt_channels.sv
// Valid/ready channel interfaces for text bytes and word results.
// Depends on no other file.
interface dwt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       in_skip;
    logic       skip_begin;
    logic       end_of_text;

    modport source (output valid, text_byte, in_skip, skip_begin, end_of_text, input ready);
    modport sink   (input valid, text_byte, in_skip, skip_begin, end_of_text, output ready);
endinterface

interface dwt_word_if;
    logic        valid;
    logic        ready;
    logic        word_valid;
    logic [15:0] word_start;
    logic [15:0] word_length;
    logic        last_result;

    modport source (output valid, word_valid, word_start, word_length, last_result,
                    input ready);
    modport sink   (input valid, word_valid, word_start, word_length, last_result,
                    output ready);
endinterface

### sv/delimiter_word_tokenizer_core.sv
// Delimiter word tokenizer core: byte stream in, word offset/length results out.
// Depends on dwt_pkg, dwt_channels and delimiter_word_tokenizer_core_defines.svh.
//
// Takes one text byte per cycle and works it in the same cycle it is accepted:
// delimiter and entity compares, span and length checks, then up to two results
// land in a four-entry result queue that drains one transaction per cycle while words.ready is high.
// Results are registered into the queue as their byte is accepted and show up on words behind any older results.
// bytes.ready is high while the queue holds two or fewer entries, so the byte
// rate is one per cycle except behind a stalled output, or while the queue drains after
// an end-of-text byte that produced both a word and the final result while two
// results were already queued.
// min_word_len resets to 1; write it only while no text is in flight.
`include "delimiter_word_tokenizer_core_defines.svh"

module delimiter_word_tokenizer_core
    import dwt_pkg::*;
#(
    parameter int MAX_TEXT_LEN = DWT_MAX_TEXT_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       min_word_len_we,
    input  logic [7:0] min_word_len,
    dwt_byte_if.sink   bytes,
    dwt_word_if.source words
);

    localparam int POS_W = $clog2(MAX_TEXT_LEN);
    localparam int LEN_W = POS_W + 1;
    localparam int QP_W  = $clog2(Q_DEPTH);
    localparam int QC_W  = QP_W + 1;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_LEN - 1);

    logic [7:0]       min_len_reg;
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [LEN_W-1:0] start_reg,   start_next;
    logic [2:0]       match_reg,   match_next;
    logic [POS_W-1:0] ent_pos_reg, ent_pos_next;

    result_t          q_mem [Q_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]  cnt_reg;

    logic             in_fire, out_fire, skip;
    logic             ent_hit, emit_a, ok_a, ok_b;
    logic [POS_W-1:0] end_a;
    logic [LEN_W-1:0] cur_p1, start_upd, len_a, len_b, min_ext;
    logic [1:0]       push_cnt;
    result_t          res_a, res_b, slot0, slot1;

    function automatic logic [LEN_W-1:0] span(input logic [LEN_W-1:0] s,
                                              input logic [LEN_W-1:0] e);
        span = (e > s) ? (e - s) : '0;
    endfunction

    function automatic logic [15:0] sat16(input logic [LEN_W-1:0] v);
        logic [31:0] w;
        w     = 32'(v);
        sat16 = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    assign in_fire  = bytes.valid && bytes.ready;
    assign out_fire = words.valid && words.ready;
    assign skip     = bytes.in_skip || bytes.skip_begin;
    assign cur_p1   = {1'b0, pos_reg} + LEN_W'(1);
    assign min_ext  = LEN_W'(min_len_reg);

    always_comb
    begin
        match_next   = match_reg;
        ent_pos_next = ent_pos_reg;
        start_upd    = start_reg;
        emit_a       = 1'b0;
        end_a        = pos_reg;
        ent_hit      = 1'b0;
        if (skip)
        begin
            match_next = '0;
            emit_a     = bytes.skip_begin;
            start_upd  = cur_p1;
        end
        else
        begin
            if (match_reg != '0)
            begin
                if (bytes.text_byte == entity_char(match_reg))
                begin
                    ent_hit = 1'b1;
                    if (match_reg == ENT_LAST_IDX)
                    begin
                        // word ends at the '&', resumes after the ';'
                        emit_a     = 1'b1;
                        end_a      = ent_pos_reg;
                        start_upd  = cur_p1;
                        match_next = '0;
                    end
                    else
                    begin
                        match_next = match_reg + 3'd1;
                    end
                end
                else
                begin
                    match_next = '0;
                end
            end
            // a byte that broke the match is treated as an ordinary byte
            if (!ent_hit)
            begin
                if (bytes.text_byte == CHAR_AMP)
                begin
                    match_next   = 3'd1;
                    ent_pos_next = pos_reg;
                end
                else if (is_delim(bytes.text_byte))
                begin
                    emit_a    = 1'b1;
                    start_upd = cur_p1;
                end
            end
        end

        len_a = span(start_reg, {1'b0, end_a});
        ok_a  = emit_a && (len_a >= min_ext);
        len_b = span(start_upd, cur_p1);
        ok_b  = (len_b >= min_ext);

        start_next = start_upd;
        pos_next   = pos_reg;
        if (bytes.end_of_text)
        begin
            pos_next     = '0;
            start_next   = '0;
            match_next   = '0;
            ent_pos_next = '0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        res_a.word_valid  = 1'b1;
        res_a.word_start  = sat16(start_reg);
        res_a.word_length = sat16(len_a);
        res_a.last_result = 1'b0;

        res_b.word_valid  = ok_b;
        res_b.word_start  = ok_b ? sat16(start_upd) : 16'd0;
        res_b.word_length = ok_b ? sat16(len_b) : 16'd0;
        res_b.last_result = 1'b1;

        slot0    = ok_a ? res_a : res_b;
        slot1    = res_b;
        push_cnt = 2'd0;
        if (in_fire)
        begin
            push_cnt = 2'(ok_a) + 2'(bytes.end_of_text);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_WORD_LEN_RESET;
        end
        else if (min_word_len_we)
        begin
            min_len_reg <= min_word_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            start_reg   <= '0;
            match_reg   <= '0;
            ent_pos_reg <= '0;
        end
        else if (in_fire)
        begin
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            match_reg   <= match_next;
            ent_pos_reg <= ent_pos_next;
        end
    end

    // result queue: up to two pushes and one pop per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QP_W'(push_cnt);
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
            cnt_reg <= cnt_reg + QC_W'(push_cnt) - QC_W'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= slot0;
        end
        if (push_cnt == 2'd2)
        begin
            q_mem[wr_ptr_reg + QP_W'(1)] <= slot1;
        end
    end

    assign bytes.ready       = (cnt_reg <= QC_W'(Q_DEPTH - 2));
    assign words.valid       = (cnt_reg != '0);
    assign words.word_valid  = q_mem[rd_ptr_reg].word_valid;
    assign words.word_start  = q_mem[rd_ptr_reg].word_start;
    assign words.word_length = q_mem[rd_ptr_reg].word_length;
    assign words.last_result = q_mem[rd_ptr_reg].last_result;

    `DWT_ASSERT(a_q_no_overflow, clk, rst_n, cnt_reg <= QC_W'(Q_DEPTH),
        "result queue overflow")
    `DWT_ASSERT(a_match_range, clk, rst_n, match_reg <= ENT_LAST_IDX,
        "entity count out of range")
    `DWT_ASSERT_NEXT(a_eot_clears, clk, rst_n, in_fire && bytes.end_of_text,
        pos_reg == '0 && start_reg == '0 && match_reg == '0,
        "state not cleared after end of text")
    `DWT_ASSERT_NEXT(a_q_count, clk, rst_n, 1'b1,
        cnt_reg == $past(cnt_reg) + QC_W'($past(push_cnt)) - QC_W'($past(out_fire)),
        "result queue count mismatch")

endmodule

### tb/testbench.sv
// Self-checking testbench for delimiter_word_tokenizer_core: drives text bytes, predicts
// the word offset/length results and compares them transaction by transaction.
// Depends on dwt_pkg, dwt_channels and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import dwt_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 290;

    typedef struct {
        logic [7:0] text_byte;
        logic       in_skip;
        logic       skip_begin;
        logic       end_of_text;
    } text_unit_t;

    // Tracks word boundaries of the text stream and holds the words still owed.
    class word_scoreboard;
        logic [7:0]  min_len;
        logic [15:0] pos;
        logic [16:0] word_from;
        logic [2:0]  ent_cnt;
        logic [15:0] ent_pos;
        result_t     expected_words[$];
        int          n_errors;

        function new();
            min_len  = MIN_WORD_LEN_RESET;
            n_errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            pos       = '0;
            word_from = '0;
            ent_cnt   = '0;
            ent_pos   = '0;
        endfunction

        function logic is_separator(logic [7:0] b);
            case (b)
                CHAR_COMMA, CHAR_SPACE, CHAR_QUOTE, CHAR_LPAREN, CHAR_RPAREN, CHAR_STAR,
                CHAR_SLASH, CHAR_COLON, CHAR_DOT, CHAR_NL, CHAR_TAB: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [7:0] nbsp_next(logic [2:0] matched);
            case (matched)
                3'd1:    return CHAR_N;
                3'd2:    return CHAR_B;
                3'd3:    return CHAR_S;
                3'd4:    return CHAR_P;
                3'd5:    return CHAR_SEMI;
                default: return CHAR_AMP;
            endcase
        endfunction

        function logic [15:0] sat16(logic [16:0] v);
            return v[16] ? 16'hFFFF : v[15:0];
        endfunction

        function logic [16:0] span_len(logic [16:0] s, logic [16:0] e);
            return (e > s) ? e - s : 17'd0;
        endfunction

        function void push_word(logic [16:0] s, logic [16:0] e);
            logic [16:0] len;
            result_t     r;
            len = span_len(s, e);
            if (len >= {9'd0, min_len}) begin
                r.word_valid  = 1'b1;
                r.word_start  = sat16(s);
                r.word_length = sat16(len);
                r.last_result = 1'b0;
                expected_words = {expected_words, r};
            end
        endfunction

        // Advance the tokenizer state by one accepted text byte.
        function void note_byte(text_unit_t u);
            logic [16:0] cur;
            logic [16:0] cur1;
            logic [16:0] len;
            logic        used;
            result_t     r;
            cur  = {1'b0, pos};
            cur1 = cur + 17'd1;
            if (u.in_skip || u.skip_begin) begin
                ent_cnt = '0;
                if (u.skip_begin)
                    push_word(word_from, cur);
                word_from = cur1;
            end else begin
                used = 1'b0;
                if (ent_cnt != 3'd0) begin
                    if (u.text_byte == nbsp_next(ent_cnt)) begin
                        used    = 1'b1;
                        ent_cnt = ent_cnt + 3'd1;
                        if (ent_cnt == 3'd6) begin
                            // the word ends at the '&', not at the ';'
                            push_word(word_from, {1'b0, ent_pos});
                            word_from = cur1;
                            ent_cnt   = '0;
                        end
                    end else begin
                        ent_cnt = '0;
                    end
                end
                if (!used) begin
                    if (u.text_byte == CHAR_AMP) begin
                        ent_cnt = 3'd1;
                        ent_pos = pos;
                    end else if (is_separator(u.text_byte)) begin
                        push_word(word_from, cur);
                        word_from = cur1;
                    end
                end
            end
            if (u.end_of_text) begin
                len = span_len(word_from, cur1);
                if (len >= {9'd0, min_len}) begin
                    r.word_valid  = 1'b1;
                    r.word_start  = sat16(word_from);
                    r.word_length = sat16(len);
                end else begin
                    r.word_valid  = 1'b0;
                    r.word_start  = '0;
                    r.word_length = '0;
                end
                r.last_result = 1'b1;
                expected_words = {expected_words, r};
                clear_text();
            end else if (int'(pos) < DWT_MAX_TEXT_LEN - 1) begin
                pos = pos + 16'd1;
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            n_errors++;
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result valid=%0b start=%0d len=%0d last=%0b",
                                          got.word_valid, got.word_start, got.word_length,
                                          got.last_result));
                return;
            end
            want = expected_words.pop_front();
            if (got.word_valid !== want.word_valid)
                report_mismatch($sformatf("word_valid got %0b want %0b",
                                          got.word_valid, want.word_valid));
            if (got.word_start !== want.word_start)
                report_mismatch($sformatf("word_start got %0d want %0d",
                                          got.word_start, want.word_start));
            if (got.word_length !== want.word_length)
                report_mismatch($sformatf("word_length got %0d want %0d",
                                          got.word_length, want.word_length));
            if (got.last_result !== want.last_result)
                report_mismatch($sformatf("last_result got %0b want %0b",
                                          got.last_result, want.last_result));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       min_len_we;
    logic [7:0] min_len_value;
    bit         idle_on = 1'b1;
    int         sink_stall = 0;

    logic [7:0] delim_chars [11] = '{CHAR_COMMA, CHAR_SPACE, CHAR_QUOTE, CHAR_LPAREN,
                                     CHAR_RPAREN, CHAR_STAR, CHAR_SLASH, CHAR_COLON,
                                     CHAR_DOT, CHAR_NL, CHAR_TAB};
    logic [7:0] nbsp_chars [6]   = '{CHAR_AMP, CHAR_N, CHAR_B, CHAR_S, CHAR_P, CHAR_SEMI};

    word_scoreboard sb = new();

    dwt_byte_if bytes_if();
    dwt_word_if words_if();

    delimiter_word_tokenizer_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .min_word_len_we (min_len_we),
        .min_word_len    (min_len_value),
        .bytes           (bytes_if),
        .words           (words_if)
    );

    always #10 clk = ~clk;

    // Result sink: check each transaction, stall ready in short random bursts while idle_on is set.
    always @(posedge clk) begin : word_sink
        result_t got;
        if (rst_n && words_if.valid && words_if.ready) begin
            got.word_valid  = words_if.word_valid;
            got.word_start  = words_if.word_start;
            got.word_length = words_if.word_length;
            got.last_result = words_if.last_result;
            sb.check_word(got);
        end
        if (sink_stall > 0) begin
            sink_stall--;
            words_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 3);
            words_if.ready <= 1'b0;
        end else begin
            words_if.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((bytes_if.valid && bytes_if.ready) || (words_if.valid && words_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("delimiter_word_tokenizer_core verification failed");
        $finish;
    end

    // Present one byte, after a random idle gap while idle_on is set, and hold it until the transaction completes.
    task automatic send_byte(input text_unit_t u);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        bytes_if.valid       <= 1'b1;
        bytes_if.text_byte   <= u.text_byte;
        bytes_if.in_skip     <= u.in_skip;
        bytes_if.skip_begin  <= u.skip_begin;
        bytes_if.end_of_text <= u.end_of_text;
        do
            @(posedge clk);
        while (!(bytes_if.valid && bytes_if.ready));
        sb.note_byte(u);
    endtask

    task automatic wait_for_drain();
        bytes_if.valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_text(input text_unit_t units[$], input bit drain_midway);
        for (int i = 0; i < units.size(); i++) begin
            if (drain_midway && i == units.size() / 2)
                wait_for_drain();
            send_byte(units[i]);
        end
    endtask

    task automatic write_min_len(input logic [7:0] value);
        wait_for_drain();
        // give the core time to settle items that produce no result
        repeat (4) @(posedge clk);
        min_len_we    <= 1'b1;
        min_len_value <= value;
        @(posedge clk);
        min_len_we <= 1'b0;
        sb.min_len = value;
    endtask

    // Build one text from words, delimiters, entities, skip ranges and noise.
    task automatic send_random_text(input bit long_words, input bit drain_midway,
                                    inout int sent);
        text_unit_t units[$];
        text_unit_t u;
        int         n_tokens;
        int         len;
        int         k;
        n_tokens = $urandom_range(1, 12);
        for (int t = 0; t < n_tokens; t++) begin
            u = '{8'h00, 1'b0, 1'b0, 1'b0};
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    len = (long_words && $urandom_range(0, 2) == 0) ?
                          $urandom_range(250, 300) : $urandom_range(1, 8);
                    repeat (len) begin
                        u.text_byte = 8'($urandom_range(8'h61, 8'h7a));
                        units = {units, u};
                    end
                end
                8, 9, 10, 11: begin
                    u.text_byte = delim_chars[$urandom_range(0, 10)];
                    units = {units, u};
                end
                12, 13: begin
                    foreach (nbsp_chars[i]) begin
                        u.text_byte = nbsp_chars[i];
                        units = {units, u};
                    end
                end
                14: begin
                    // partial entity, then maybe a byte that breaks it
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++) begin
                        u.text_byte = nbsp_chars[i];
                        units = {units, u};
                    end
                    case ($urandom_range(0, 3))
                        0: u.text_byte = delim_chars[$urandom_range(0, 10)];
                        1: u.text_byte = CHAR_AMP;
                        2: u.text_byte = 8'($urandom_range(8'h61, 8'h7a));
                        default: u.text_byte = 8'h00;
                    endcase
                    if (u.text_byte != 8'h00)
                        units = {units, u};
                end
                15: begin
                    // entity with one byte inside a skip range
                    k = $urandom_range(0, 5);
                    foreach (nbsp_chars[i]) begin
                        u.text_byte  = nbsp_chars[i];
                        u.in_skip    = (i == k);
                        u.skip_begin = (i == k) && ($urandom_range(0, 1) == 1);
                        units = {units, u};
                    end
                end
                16, 17: begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++) begin
                        u.text_byte  = 8'($urandom_range(0, 255));
                        u.skip_begin = (i == 0);
                        u.in_skip    = (i != 0) || ($urandom_range(0, 1) == 1);
                        units = {units, u};
                    end
                end
                18: begin
                    u.text_byte  = 8'($urandom_range(0, 255));
                    u.in_skip    = ($urandom_range(0, 3) == 0);
                    u.skip_begin = ($urandom_range(0, 5) == 0);
                    units = {units, u};
                end
                default: begin
                    u.text_byte = CHAR_AMP;
                    units = {units, u};
                    foreach (nbsp_chars[i]) begin
                        u.text_byte = nbsp_chars[i];
                        units = {units, u};
                    end
                end
            endcase
        end
        if (units.size() == 0) begin
            u = '{8'($urandom_range(8'h61, 8'h7a)), 1'b0, 1'b0, 1'b0};
            units = {units, u};
        end
        units[units.size() - 1].end_of_text = 1'b1;
        send_text(units, drain_midway);
        sent += units.size();
    endtask

    initial begin : stimulus
        text_unit_t directed[$];
        logic [7:0] plain [20];
        logic [7:0] phase_min_len [6];
        int         sent;

        rst_n                <= 1'b0;
        min_len_we           <= 1'b0;
        min_len_value        <= 8'd0;
        bytes_if.valid       <= 1'b0;
        bytes_if.text_byte   <= 8'd0;
        bytes_if.in_skip     <= 1'b0;
        bytes_if.skip_begin  <= 1'b0;
        bytes_if.end_of_text <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text at the reset minimum: byte extremes, a full entity,
        // every delimiter, a broken entity, skip bytes, then a bare end marker.
        plain = '{8'h61, 8'h00, CHAR_COMMA, 8'hFF, CHAR_AMP, CHAR_N, CHAR_B, CHAR_S,
                  CHAR_P, CHAR_SEMI, CHAR_SPACE, CHAR_QUOTE, CHAR_LPAREN, CHAR_RPAREN,
                  CHAR_STAR, CHAR_SLASH, CHAR_COLON, CHAR_DOT, CHAR_NL, CHAR_TAB};
        foreach (plain[i])
            directed = {directed, text_unit_t'{plain[i], 1'b0, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{CHAR_AMP, 1'b0, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{CHAR_N, 1'b0, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{8'h78, 1'b0, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{8'h6B, 1'b0, 1'b1, 1'b0}};
        directed = {directed, text_unit_t'{8'h6D, 1'b1, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{8'h71, 1'b0, 1'b0, 1'b0}};
        directed = {directed, text_unit_t'{CHAR_SEMI, 1'b0, 1'b0, 1'b1}};
        directed = {directed, text_unit_t'{CHAR_DOT, 1'b0, 1'b0, 1'b1}};
        send_text(directed, 1'b0);

        phase_min_len = '{8'd3, 8'd255, 8'd1, 8'($urandom_range(2, 8)), 8'd0, 8'd2};
        foreach (phase_min_len[p]) begin
            write_min_len(phase_min_len[p]);
            if (p == 5)
                idle_on = 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_random_text(phase_min_len[p] == 8'd255, (p == 0) && (sent == 0), sent);
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (sb.n_errors == 0)
            $display("delimiter_word_tokenizer_core verification clean");
        else
            $display("delimiter_word_tokenizer_core verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/dwt_pkg.sv
sv/dwt_channels.sv
sv/delimiter_word_tokenizer_core.sv
tb/testbench.sv
